FILE: rtl/unicode_escape_to_utf8_core_defines.svh
// Assertion macros for the escape decoder; empty bodies when SYNTHESIS is defined.
`ifndef UNICODE_ESCAPE_TO_UTF8_CORE_DEFINES_SVH
`define UNICODE_ESCAPE_TO_UTF8_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UE8_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ue8: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UE8_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ue8: next-cycle check failed");
`else
`define UE8_ASSERT_NOW(lbl, ante, cons)
`define UE8_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/ue8_pkg.sv
// Types, constants and hex decode shared by the escape decoder.
`timescale 1ns / 1ps
`default_nettype none

package ue8_pkg;

  localparam int MAX_RESULTS = 3;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam logic [15:0] CP_MAX_1B = 16'h007F;
  localparam logic [15:0] CP_MAX_2B = 16'h07FF;
  localparam logic [7:0]  LEAD_2B   = 8'hC0;
  localparam logic [7:0]  LEAD_3B   = 8'hE0;
  localparam logic [7:0]  CONT_BYTE = 8'h80;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_SLASH  = 2'd1,
    PH_HEX    = 2'd2,
    PH_BAD    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_done;
    logic       bad_escape;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ue8_stream_if.sv
// Valid/ready stream channel carrying one payload struct.
`timescale 1ns / 1ps
`default_nettype none

interface ue8_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/unicode_escape_to_utf8_core.sv
// Top level: streaming \uXXXX escape decoder producing UTF-8 bytes.
`timescale 1ns / 1ps
`default_nettype none
`include "unicode_escape_to_utf8_core_defines.svh"

// Channel  Dir  Payload                                             Transfer when
// -------  ---  --------------------------------------------------  -------------
// in_ch    in   in_byte[7:0], in_last                               valid & ready
// out_ch   out  out_byte[7:0], byte_valid, run_last,                valid & ready
//               string_done, bad_escape
//
// An input byte is held in the input register until it advances, is decoded in
// one pass into up to three results, and those sit in a three-entry result
// buffer that drains one result per cycle while the output is ready. Throughput
// is one byte per cycle while each byte gives at most one result and the output
// is ready; a byte giving several results holds the buffer until its last one
// transfers. Each byte passes the input register, then the result buffer.
// Reset (rst_n low, synchronous) empties both registers and clears scan state.
// The input register still takes one byte while a finished result waits on a
// stalled output; then the input stalls until the buffer is down to its last
// result and the output is ready.

module unicode_escape_to_utf8_core
  import ue8_pkg::*;
(
  input  wire           clk,
  input  wire           rst_n,
  ue8_stream_if.sink    in_ch,
  ue8_stream_if.source  out_ch
);

  // Input register
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      s1_adv;
  logic      in_xfer;

  // Scan state
  phase_t        phase_r, phase_nxt;
  logic [1:0]    digits_r, digits_nxt;
  logic [15:0]   code_r, code_nxt;

  // Result buffer; entry 0 faces the output
  out_item_t        buf_r [MAX_RESULTS];
  logic [CNT_W-1:0] cnt_r;
  logic             buf_free;
  logic             out_xfer;

  // Decode of the held byte
  logic [7:0]       b;
  logic             last;
  hex_t             hx;
  logic [15:0]      code_shift;
  logic             bad;
  logic [CNT_W-1:0] res_n;
  logic [7:0]       res_byte [MAX_RESULTS];
  out_item_t        res      [MAX_RESULTS];

  // Check terms
  logic             err_form_ok;
  logic             scan_idle;

  // ---------------------------------------------------------------------------
  // Handshakes: the input register frees up whenever its item moves into the
  // result buffer, so a new byte can land in the same cycle.
  // ---------------------------------------------------------------------------
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign buf_free = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ch.ready);
  assign s1_adv   = s1_valid_r && buf_free;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign out_ch.valid   = (cnt_r != '0);
  assign out_ch.payload = buf_r[0];

  // ---------------------------------------------------------------------------
  // Shared decode terms
  // ---------------------------------------------------------------------------
  assign b          = s1_item_r.in_byte;
  assign last       = s1_item_r.in_last;
  assign hx         = hex_decode(b);
  assign code_shift = {code_r[11:0], hx.val};

  // A malformed or truncated escape voids the string.
  always_comb begin
    unique case (phase_r)
      PH_NORMAL: bad = 1'b0;
      PH_SLASH:  bad = (b == CH_U) && last;
      PH_HEX:    bad = !hx.ok || ((digits_r != 2'd3) && last);
      PH_BAD:    bad = 1'b1;
      default:   bad = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Next scan state
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_nxt  = phase_r;
    digits_nxt = digits_r;
    code_nxt   = code_r;
    if (last) begin
      // every string end returns to the reset state
      phase_nxt  = PH_NORMAL;
      digits_nxt = 2'd0;
      code_nxt   = 16'd0;
    end else if (bad) begin
      phase_nxt = PH_BAD;
    end else begin
      unique case (phase_r)
        PH_NORMAL: begin
          if (b == CH_BACKSLASH) phase_nxt = PH_SLASH;
        end
        PH_SLASH: begin
          if (b == CH_U) begin
            phase_nxt  = PH_HEX;
            digits_nxt = 2'd0;
            code_nxt   = 16'd0;
          end else if (b != CH_BACKSLASH) begin
            phase_nxt = PH_NORMAL;
          end
        end
        PH_HEX: begin
          code_nxt = code_shift;
          if (digits_r == 2'd3) begin
            phase_nxt  = PH_NORMAL;
            digits_nxt = 2'd0;
          end else begin
            digits_nxt = digits_r + 2'd1;
          end
        end
        default: phase_nxt = PH_BAD;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Results for the held byte
  // ---------------------------------------------------------------------------
  always_comb begin
    res_n = '0;
    for (int i = 0; i < MAX_RESULTS; i++) res_byte[i] = 8'd0;
    if (!bad) begin
      unique case (phase_r)
        PH_NORMAL: begin
          if (!((b == CH_BACKSLASH) && !last)) begin
            res_n       = CNT_W'(1);
            res_byte[0] = b;
          end
        end
        PH_SLASH: begin
          if (b == CH_U) begin
            res_n = '0;
          end else if ((b == CH_BACKSLASH) && !last) begin
            // first backslash goes out literally, second may open an escape
            res_n       = CNT_W'(1);
            res_byte[0] = CH_BACKSLASH;
          end else begin
            res_n       = CNT_W'(2);
            res_byte[0] = CH_BACKSLASH;
            res_byte[1] = b;
          end
        end
        PH_HEX: begin
          if (digits_r == 2'd3) begin
            if (code_shift <= CP_MAX_1B) begin
              res_n       = CNT_W'(1);
              res_byte[0] = code_shift[7:0];
            end else if (code_shift <= CP_MAX_2B) begin
              res_n       = CNT_W'(2);
              res_byte[0] = LEAD_2B | {3'd0, code_shift[10:6]};
              res_byte[1] = CONT_BYTE | {2'd0, code_shift[5:0]};
            end else begin
              res_n       = CNT_W'(3);
              res_byte[0] = LEAD_3B | {4'd0, code_shift[15:12]};
              res_byte[1] = CONT_BYTE | {2'd0, code_shift[11:6]};
              res_byte[2] = CONT_BYTE | {2'd0, code_shift[5:0]};
            end
          end
        end
        default: res_n = '0;
      endcase
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i].out_byte    = res_byte[i];
      res[i].byte_valid  = 1'b1;
      res[i].run_last    = (CNT_W'(i) == res_n - CNT_W'(1));
      res[i].string_done = (CNT_W'(i) == res_n - CNT_W'(1)) && last;
      res[i].bad_escape  = 1'b0;
    end

    // a voided string yields one error result, only with its last byte
    if (bad) begin
      res_n              = last ? CNT_W'(1) : '0;
      res[0].out_byte    = 8'd0;
      res[0].byte_valid  = 1'b0;
      res[0].run_last    = 1'b1;
      res[0].string_done = 1'b1;
      res[0].bad_escape  = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= PH_NORMAL;
      digits_r   <= 2'd0;
      code_r     <= 16'd0;
      cnt_r      <= '0;
    end else begin
      // hold the input register unless it advances or a new byte lands
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      // advance scan state only as the held byte is consumed
      if (s1_adv) begin
        phase_r  <= phase_nxt;
        digits_r <= digits_nxt;
        code_r   <= code_nxt;
        cnt_r    <= res_n;
      end else if (out_xfer) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_ch.payload;
    end
    if (s1_adv) begin
      for (int i = 0; i < MAX_RESULTS; i++) buf_r[i] <= res[i];
    end else if (out_xfer) begin
      // drop the delivered result, shift the rest forward
      for (int i = 0; i < MAX_RESULTS - 1; i++) buf_r[i] <= buf_r[i + 1];
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  assign err_form_ok = out_ch.payload.string_done && out_ch.payload.run_last &&
                       !out_ch.payload.byte_valid;
  assign scan_idle   = (phase_r == PH_NORMAL) && (digits_r == 2'd0) && (code_r == 16'd0);

  `UE8_ASSERT_NOW(a_run_last_ends_buffer, out_ch.valid && out_ch.payload.run_last, cnt_r == CNT_W'(1))
  `UE8_ASSERT_NOW(a_error_result_form, out_ch.valid && out_ch.payload.bad_escape, err_form_ok)
  `UE8_ASSERT_NEXT(a_state_clear_after_last, s1_adv && last, scan_idle)
  `UE8_ASSERT_NEXT(a_held_byte_kept, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_item_r))

endmodule

`default_nettype wire
